>>> hw/rtl/looped_pulse_pattern_sequencer_macros.svh
// Assertion macros shared by the pulse pattern sequencer RTL.
`ifndef LOOPED_PULSE_PATTERN_SEQUENCER_MACROS_SVH
`define LOOPED_PULSE_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LPPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LPPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lpps_pkg.sv
// Types and constants of the looped pulse pattern sequencer.
package lpps_pkg;

  localparam int TICK_W = 32;
  localparam int RES_CNT_W = 5;
  localparam logic [RES_CNT_W-1:0] RES_CAP = 5'd16;
  localparam logic [2:0] IFACE_LAST = 3'd5;
  localparam logic EV_PIN = 1'b0;
  localparam logic EV_NOTICE = 1'b1;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_START  = 3'd1,
    OP_TICK   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_STOP   = 3'd5,
    OP_ABORT  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [2:0]        iface_code;
    logic [5:0]        pin_number;
    logic [TICK_W-1:0] on_offset;
    logic [TICK_W-1:0] on_duration;
  } in_item_t;

  typedef struct packed {
    logic       event_kind;
    logic [2:0] out_iface;
    logic [5:0] out_pin;
    logic       level;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        iface;
    logic [5:0]        pin;
    logic [TICK_W-1:0] offset;
    logic [TICK_W-1:0] duration;
  } chan_entry_t;

endpackage

>>> hw/rtl/lpps_table.sv
// Channel table memory with one write port and one registered read port.
module lpps_table #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lpps_pkg::chan_entry_t wr_entry,
  input  logic [AW-1:0]        rd_addr,
  output lpps_pkg::chan_entry_t rd_entry
);

  lpps_pkg::chan_entry_t mem_r [DEPTH];
  lpps_pkg::chan_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry_r <= mem_r[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

>>> hw/rtl/lpps_cmp.sv
// Shared edge-time unit: forms the switch time of one channel and compares it.
module lpps_cmp (
  input  logic [lpps_pkg::TICK_W-1:0] offset,
  input  logic [lpps_pkg::TICK_W-1:0] duration,
  input  logic [lpps_pkg::TICK_W-1:0] elapsed,
  input  logic                        is_on,
  output logic                        hit
);

  logic [lpps_pkg::TICK_W:0] edge_time;

  always_comb begin
    if (is_on) begin
      edge_time = {1'b0, offset} + {1'b0, duration};
    end else begin
      edge_time = {1'b0, offset};
    end
  end

  assign hit = edge_time <= {1'b0, elapsed};

endmodule

>>> hw/rtl/looped_pulse_pattern_sequencer.sv
// Top level of the looped pulse pattern sequencer.
// Requests arrive on in_valid/in_ready with an in_data struct. While idle, load
// requests append channels and each valid load returns one pin-low event. Start
// begins a run; a tick request then scans the channel table and returns the
// resulting pin level changes on out_valid/out_ready, the final one flagged last.
// A tick returns at most RES_CAP results. Stop outside pause mode returns one
// loop-stopped notice. The loop pause is written on cfg_*. Load and stop hand
// over their result through the flush state; start, pause, resume and abort
// return none. A tick scans one channel per cycle through the shared edge-time
// unit and the registered table read port, unless a held result stalls the
// scan; a tick inside the pause gap or with an empty table does no scan.
// in_ready is low while a request is in progress. A result waits in the output
// register while the receiver stalls; a scan holds its place when a second
// result cannot move forward, and resumes when out_ready returns.
// Reset empties the table and clears the flags, the run mode and the counters.
module looped_pulse_pattern_sequencer #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lpps_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lpps_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpps_pkg::TICK_W-1:0]   cfg_data
);

`include "looped_pulse_pattern_sequencer_macros.svh"

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHANNELS);

  lpps_pkg::state_t                  state_r, state_nxt;
  lpps_pkg::mode_t                   mode_r, mode_nxt;
  logic [CNT_W-1:0]                  chan_count_r, chan_count_nxt;
  logic [CNT_W-1:0]                  idx_r, idx_nxt;
  logic [MAX_CHANNELS-1:0]           chan_on_r, chan_on_nxt;
  logic [MAX_CHANNELS-1:0]           chan_done_r, chan_done_nxt;
  logic [lpps_pkg::TICK_W-1:0]       elapsed_r, elapsed_nxt;
  logic [lpps_pkg::TICK_W-1:0]       gap_r, gap_nxt;
  logic [lpps_pkg::TICK_W-1:0]       loop_pause_r, loop_pause_nxt;
  logic                              pend_r, pend_nxt;
  logic [lpps_pkg::RES_CNT_W-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic                              hold_valid_r, hold_valid_nxt;
  lpps_pkg::out_item_t               hold_data_r, hold_data_nxt;
  logic                              out_valid_r, out_valid_nxt;
  lpps_pkg::out_item_t               out_data_r, out_data_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  do_load;
  logic                  do_tick;
  logic                  do_scan;
  logic                  do_stop;
  logic [IDX_W-1:0]      cur_idx;
  logic [CNT_W-1:0]      idx_inc;
  logic                  cur_on;
  logic                  cur_done;
  logic                  hit;
  logic                  scan_emit;
  logic                  scan_stall;
  logic                  scan_step;
  logic                  scan_last;
  logic                  scan_hold;
  logic                  scan_pending;
  logic [IDX_W-1:0]      rd_addr;
  lpps_pkg::chan_entry_t wr_entry;
  lpps_pkg::chan_entry_t cur;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign do_load = in_fire && (in_data.operation == lpps_pkg::OP_LOAD)
                   && (mode_r == lpps_pkg::MODE_IDLE)
                   && (in_data.iface_code <= lpps_pkg::IFACE_LAST)
                   && (chan_count_r < CNT_MAX);
  assign do_tick = in_fire && (in_data.operation == lpps_pkg::OP_TICK)
                   && (mode_r == lpps_pkg::MODE_RUN);
  assign do_scan = do_tick && (gap_r == '0) && (chan_count_r != '0);
  assign do_stop = in_fire && (in_data.operation == lpps_pkg::OP_STOP)
                   && (mode_r != lpps_pkg::MODE_PAUSE);

  assign cur_idx      = idx_r[IDX_W-1:0];
  assign idx_inc      = idx_r + CNT_W'(1);
  assign cur_on       = chan_on_r[cur_idx];
  assign cur_done     = chan_done_r[cur_idx];
  assign scan_emit    = (state_r == lpps_pkg::ST_SCAN) && !cur_done && hit
                        && (emit_cnt_r < lpps_pkg::RES_CAP);
  assign scan_stall   = scan_emit && hold_valid_r && !out_free;
  assign scan_step    = (state_r == lpps_pkg::ST_SCAN) && !scan_stall;
  assign scan_last    = idx_inc == chan_count_r;
  assign scan_hold    = hold_valid_r || scan_emit;
  assign scan_pending = pend_r || !cur_done;

  always_comb begin
    if (state_r != lpps_pkg::ST_SCAN) begin
      rd_addr = '0;
    end else if (scan_step) begin
      rd_addr = idx_inc[IDX_W-1:0];
    end else begin
      rd_addr = cur_idx;
    end
  end

  assign wr_entry.iface    = in_data.iface_code;
  assign wr_entry.pin      = in_data.pin_number;
  assign wr_entry.offset   = in_data.on_offset;
  assign wr_entry.duration = in_data.on_duration;

  lpps_table #(
    .DEPTH (MAX_CHANNELS),
    .AW    (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (do_load),
    .wr_addr  (chan_count_r[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (cur)
  );

  lpps_cmp u_cmp (
    .offset   (cur.offset),
    .duration (cur.duration),
    .elapsed  (elapsed_r),
    .is_on    (cur_on),
    .hit      (hit)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpps_pkg::ST_IDLE: begin
        if (do_load || do_stop) begin
          state_nxt = lpps_pkg::ST_FLUSH;
        end else if (do_scan) begin
          state_nxt = lpps_pkg::ST_SCAN;
        end
      end
      lpps_pkg::ST_SCAN: begin
        if (scan_step && scan_last) begin
          state_nxt = scan_hold ? lpps_pkg::ST_FLUSH : lpps_pkg::ST_IDLE;
        end
      end
      lpps_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_nxt = lpps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mode_nxt       = mode_r;
    chan_count_nxt = chan_count_r;
    idx_nxt        = idx_r;
    chan_on_nxt    = chan_on_r;
    chan_done_nxt  = chan_done_r;
    elapsed_nxt    = elapsed_r;
    gap_nxt        = gap_r;
    loop_pause_nxt = loop_pause_r;
    pend_nxt       = pend_r;
    emit_cnt_nxt   = emit_cnt_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (cfg_valid) begin
      loop_pause_nxt = cfg_data;
    end

    if (in_fire) begin
      case (in_data.operation)
        lpps_pkg::OP_LOAD: begin
          if (do_load) begin
            chan_count_nxt                          = chan_count_r + CNT_W'(1);
            chan_on_nxt[chan_count_r[IDX_W-1:0]]    = 1'b0;
            chan_done_nxt[chan_count_r[IDX_W-1:0]]  = 1'b0;
            hold_valid_nxt                          = 1'b1;
            hold_data_nxt.event_kind                = lpps_pkg::EV_PIN;
            hold_data_nxt.out_iface                 = in_data.iface_code;
            hold_data_nxt.out_pin                   = in_data.pin_number;
            hold_data_nxt.level                     = 1'b0;
            hold_data_nxt.last                      = 1'b0;
          end
        end
        lpps_pkg::OP_START: begin
          if (mode_r == lpps_pkg::MODE_IDLE) begin
            mode_nxt    = lpps_pkg::MODE_RUN;
            elapsed_nxt = '0;
            gap_nxt     = '0;
          end
        end
        lpps_pkg::OP_TICK: begin
          if (do_tick) begin
            if (gap_r != '0) begin
              gap_nxt = gap_r - lpps_pkg::TICK_W'(1);
            end else if (chan_count_r == '0) begin
              chan_on_nxt   = '0;
              chan_done_nxt = '0;
              elapsed_nxt   = '0;
              gap_nxt       = loop_pause_r;
            end else begin
              idx_nxt      = '0;
              pend_nxt     = 1'b0;
              emit_cnt_nxt = '0;
            end
          end
        end
        lpps_pkg::OP_PAUSE: begin
          if (mode_r == lpps_pkg::MODE_RUN) begin
            chan_on_nxt   = '0;
            chan_done_nxt = '0;
            mode_nxt      = lpps_pkg::MODE_PAUSE;
          end
        end
        lpps_pkg::OP_RESUME: begin
          if (mode_r == lpps_pkg::MODE_PAUSE) begin
            mode_nxt    = lpps_pkg::MODE_RUN;
            elapsed_nxt = '0;
            gap_nxt     = '0;
          end
        end
        lpps_pkg::OP_STOP: begin
          if (do_stop) begin
            chan_count_nxt           = '0;
            chan_on_nxt              = '0;
            chan_done_nxt            = '0;
            mode_nxt                 = lpps_pkg::MODE_IDLE;
            elapsed_nxt              = '0;
            gap_nxt                  = '0;
            hold_valid_nxt           = 1'b1;
            hold_data_nxt.event_kind = lpps_pkg::EV_NOTICE;
            hold_data_nxt.out_iface  = '0;
            hold_data_nxt.out_pin    = '0;
            hold_data_nxt.level      = 1'b0;
            hold_data_nxt.last       = 1'b0;
          end
        end
        lpps_pkg::OP_ABORT: begin
          chan_count_nxt = '0;
          chan_on_nxt    = '0;
          chan_done_nxt  = '0;
          mode_nxt       = lpps_pkg::MODE_IDLE;
          elapsed_nxt    = '0;
          gap_nxt        = '0;
        end
        default: begin
        end
      endcase
    end

    if (scan_step) begin
      if (!cur_done && hit) begin
        if (cur_on) begin
          chan_done_nxt[cur_idx] = 1'b1;
        end else begin
          chan_on_nxt[cur_idx] = 1'b1;
        end
      end
      if (scan_emit) begin
        emit_cnt_nxt = emit_cnt_r + lpps_pkg::RES_CNT_W'(1);
        if (hold_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hold_data_r;
        end
        hold_valid_nxt           = 1'b1;
        hold_data_nxt.event_kind = lpps_pkg::EV_PIN;
        hold_data_nxt.out_iface  = cur.iface;
        hold_data_nxt.out_pin    = cur.pin;
        hold_data_nxt.level      = !cur_on;
        hold_data_nxt.last       = 1'b0;
      end
      pend_nxt = scan_pending;
      idx_nxt  = idx_inc;
      if (scan_last) begin
        if (!scan_pending) begin
          chan_on_nxt   = '0;
          chan_done_nxt = '0;
          elapsed_nxt   = '0;
          gap_nxt       = loop_pause_r;
        end else if (elapsed_r != '1) begin
          elapsed_nxt = elapsed_r + lpps_pkg::TICK_W'(1);
        end
      end
    end

    if ((state_r == lpps_pkg::ST_FLUSH) && out_free) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt      = hold_data_r;
      out_data_nxt.last = 1'b1;
      hold_valid_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lpps_pkg::ST_IDLE;
      mode_r       <= lpps_pkg::MODE_IDLE;
      chan_count_r <= '0;
      idx_r        <= '0;
      chan_on_r    <= '0;
      chan_done_r  <= '0;
      elapsed_r    <= '0;
      gap_r        <= '0;
      loop_pause_r <= '0;
      pend_r       <= 1'b0;
      emit_cnt_r   <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      chan_count_r <= chan_count_nxt;
      idx_r        <= idx_nxt;
      chan_on_r    <= chan_on_nxt;
      chan_done_r  <= chan_done_nxt;
      elapsed_r    <= elapsed_nxt;
      gap_r        <= gap_nxt;
      loop_pause_r <= loop_pause_nxt;
      pend_r       <= pend_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_data_r <= hold_data_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = state_r == lpps_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LPPS_ASSERT_NOW(a_idle_hold_empty, state_r == lpps_pkg::ST_IDLE, !hold_valid_r, "pending result left behind in idle")
  `LPPS_ASSERT_NOW(a_scan_runs, state_r == lpps_pkg::ST_SCAN, mode_r == lpps_pkg::MODE_RUN, "scan outside run mode")
  `LPPS_ASSERT_NOW(a_count_bound, 1'b1, chan_count_r <= CNT_MAX, "channel count beyond table depth")
  `LPPS_ASSERT_NOW(a_emit_bound, 1'b1, emit_cnt_r <= lpps_pkg::RES_CAP, "result count beyond cap")
  `LPPS_ASSERT_NEXT(a_flush_hold, state_r == lpps_pkg::ST_FLUSH && !out_free, hold_valid_r && state_r == lpps_pkg::ST_FLUSH, "flush lost its result")

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the looped pulse pattern sequencer: directed table, random patterns, self-check.
`timescale 1ns / 1ps

module tb_top;
  import lpps_pkg::*;

  localparam int CHAN_SLOTS = 16;
  localparam int REQ_TARGET = 410;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [2:0] OP_UNDEF = 3'd7;
  localparam out_item_t STOP_NOTICE = '{EV_NOTICE, 3'd0, 6'd0, 1'b0, 1'b1};

  typedef struct {
    in_item_t  req;
    bit        typed;
    bit        has_evt;
    out_item_t evt;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TICK_W-1:0] cfg_data = '0;

  logic [2:0] chan_iface [CHAN_SLOTS];
  logic [5:0] chan_pin [CHAN_SLOTS];
  logic [TICK_W-1:0] chan_offset [CHAN_SLOTS];
  logic [TICK_W-1:0] chan_duration [CHAN_SLOTS];
  bit chan_on [CHAN_SLOTS];
  bit chan_done [CHAN_SLOTS];
  int chan_total;
  mode_t seq_mode;
  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] gap_left;
  logic [TICK_W-1:0] pause_ticks;

  out_item_t step_events [$];
  out_item_t pin_events_due [$];
  dir_row_t dir_rows [$];
  int active_reqs = 0;
  int errors = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int cycles = 0;

  looped_pulse_pattern_sequencer #(.MAX_CHANNELS(CHAN_SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic void add_event(logic kind, logic [2:0] ifc, logic [5:0] pin, logic lvl);
    if (step_events.size() < int'(RES_CAP))
      step_events.insert(step_events.size(), '{kind, ifc, pin, lvl, 1'b0});
  endfunction

  function automatic void clear_flags();
    for (int i = 0; i < CHAN_SLOTS; i++) begin
      chan_on[i] = 1'b0;
      chan_done[i] = 1'b0;
    end
  endfunction

  function automatic void clear_sequencer();
    for (int i = 0; i < CHAN_SLOTS; i++) begin
      chan_iface[i] = '0;
      chan_pin[i] = '0;
      chan_offset[i] = '0;
      chan_duration[i] = '0;
    end
    clear_flags();
    chan_total = 0;
    seq_mode = MODE_IDLE;
    elapsed = '0;
    gap_left = '0;
  endfunction

  // Returns 1 when the request changes the sequencer state.
  function automatic bit predict_pin_events(in_item_t req);
    bit acted;
    bit pending;
    logic [TICK_W:0] off_end;
    acted = 1'b0;
    pending = 1'b0;
    step_events.delete();
    case (req.operation)
      OP_LOAD: begin
        if (seq_mode == MODE_IDLE && req.iface_code <= IFACE_LAST && chan_total < CHAN_SLOTS) begin
          chan_iface[chan_total] = req.iface_code;
          chan_pin[chan_total] = req.pin_number;
          chan_offset[chan_total] = req.on_offset;
          chan_duration[chan_total] = req.on_duration;
          chan_on[chan_total] = 1'b0;
          chan_done[chan_total] = 1'b0;
          chan_total++;
          add_event(EV_PIN, req.iface_code, req.pin_number, 1'b0);
          acted = 1'b1;
        end
      end
      OP_START: begin
        if (seq_mode == MODE_IDLE) begin
          seq_mode = MODE_RUN;
          elapsed = '0;
          gap_left = '0;
          acted = 1'b1;
        end
      end
      OP_TICK: begin
        if (seq_mode == MODE_RUN) begin
          acted = 1'b1;
          if (gap_left != '0) begin
            gap_left--;
          end else begin
            for (int i = 0; i < chan_total; i++) begin
              if (!chan_done[i]) begin
                pending = 1'b1;
                if (chan_on[i]) begin
                  off_end = {1'b0, chan_offset[i]} + {1'b0, chan_duration[i]};
                  if (off_end <= {1'b0, elapsed}) begin
                    chan_done[i] = 1'b1;
                    add_event(EV_PIN, chan_iface[i], chan_pin[i], 1'b0);
                  end
                end else if (chan_offset[i] <= elapsed) begin
                  chan_on[i] = 1'b1;
                  add_event(EV_PIN, chan_iface[i], chan_pin[i], 1'b1);
                end
              end
            end
            if (!pending) begin
              clear_flags();
              elapsed = '0;
              gap_left = pause_ticks;
            end else if (elapsed != '1) begin
              elapsed++;
            end
          end
        end
      end
      OP_PAUSE: begin
        if (seq_mode == MODE_RUN) begin
          clear_flags();
          seq_mode = MODE_PAUSE;
          acted = 1'b1;
        end
      end
      OP_RESUME: begin
        if (seq_mode == MODE_PAUSE) begin
          seq_mode = MODE_RUN;
          elapsed = '0;
          gap_left = '0;
          acted = 1'b1;
        end
      end
      OP_STOP: begin
        if (seq_mode != MODE_PAUSE) begin
          add_event(EV_NOTICE, 3'd0, 6'd0, 1'b0);
          clear_sequencer();
          acted = 1'b1;
        end
      end
      OP_ABORT: begin
        clear_sequencer();
        acted = 1'b1;
      end
      default: begin
      end
    endcase
    if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
    return acted;
  endfunction

  function automatic in_item_t mk_req(logic [2:0] op, logic [2:0] ifc, logic [5:0] pin,
                                      logic [TICK_W-1:0] off, logic [TICK_W-1:0] dur);
    in_item_t r;
    r.operation = op;
    r.iface_code = ifc;
    r.pin_number = pin;
    r.on_offset = off;
    r.on_duration = dur;
    return r;
  endfunction

  function automatic in_item_t ctrl_req(logic [2:0] op);
    return mk_req(op, 3'($urandom), 6'($urandom), $urandom, $urandom);
  endfunction

  function automatic in_item_t load_req();
    logic [2:0] ifc;
    logic [TICK_W-1:0] off;
    logic [TICK_W-1:0] dur;
    int r;
    ifc = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    r = $urandom_range(0, 15);
    off = (r == 0) ? $urandom : (r == 1) ? '1 : $urandom_range(0, 8);
    r = $urandom_range(0, 15);
    dur = (r == 0) ? $urandom : (r == 1) ? '1 : $urandom_range(0, 6);
    return mk_req(OP_LOAD, ifc, 6'($urandom), off, dur);
  endfunction

  function automatic void add_row(in_item_t req, bit typed, bit has_evt, out_item_t evt);
    dir_row_t row;
    row.req = req;
    row.typed = typed;
    row.has_evt = has_evt;
    row.evt = evt;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic out_item_t low_evt(logic [2:0] ifc, logic [5:0] pin);
    return '{EV_PIN, ifc, pin, 1'b0, 1'b1};
  endfunction

  task automatic hold_requests(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_req(in_item_t req, bit typed = 1'b0, bit has_evt = 1'b0,
                          out_item_t evt = '0);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) hold_requests($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    void'(predict_pin_events(req));
    active_reqs++;
    if (typed) begin
      step_events.delete();
      if (has_evt) step_events.insert(0, evt);
    end
    foreach (step_events[k]) pin_events_due.insert(pin_events_due.size(), step_events[k]);
  endtask

  task automatic write_loop_pause(logic [TICK_W-1:0] val);
    hold_requests(1);
    while (pin_events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    pause_ticks = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_pattern();
    int nloads;
    int nticks;
    int r;
    if (seq_mode == MODE_PAUSE || $urandom_range(0, 1) == 0) send_req(ctrl_req(OP_ABORT));
    else if (seq_mode != MODE_IDLE) send_req(ctrl_req(OP_STOP));
    nloads = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 6);
    repeat (nloads) send_req(load_req());
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: send_req(ctrl_req(OP_PAUSE));
        1: send_req(ctrl_req(OP_RESUME));
        2: send_req(ctrl_req(OP_TICK));
        default: send_req(ctrl_req(OP_UNDEF));
      endcase
    end
    send_req(ctrl_req(OP_START));
    nticks = $urandom_range(6, 30);
    for (int t = 0; t < nticks; t++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_req(ctrl_req(OP_PAUSE));
        if ($urandom_range(0, 1) == 0) send_req(ctrl_req(OP_STOP));
        if ($urandom_range(0, 1) == 0) send_req(ctrl_req(OP_TICK));
        if ($urandom_range(0, 4) == 0) begin
          send_req(ctrl_req(OP_ABORT));
          return;
        end
        send_req(ctrl_req(OP_RESUME));
      end else if (r == 1) begin
        case ($urandom_range(0, 3))
          0: send_req(load_req());
          1: send_req(ctrl_req(OP_START));
          2: send_req(ctrl_req(OP_RESUME));
          default: send_req(ctrl_req(OP_UNDEF));
        endcase
      end else begin
        send_req(ctrl_req(OP_TICK));
      end
    end
    r = $urandom_range(0, 2);
    if (r == 0) send_req(ctrl_req(OP_STOP));
    else if (r == 1) send_req(ctrl_req(OP_ABORT));
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_left % 8 == 0);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pin_events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind=%0d iface=%0d pin=%0d level=%0d last=%0d",
                 $time, out_data.event_kind, out_data.out_iface, out_data.out_pin,
                 out_data.level, out_data.last);
      end else begin
        want = pin_events_due.pop_front();
        if (want.event_kind !== out_data.event_kind || want.out_iface !== out_data.out_iface ||
            want.out_pin !== out_data.out_pin || want.level !== out_data.level ||
            want.last !== out_data.last) begin
          errors++;
          $display("%0t: mismatch, expected kind=%0d iface=%0d pin=%0d level=%0d last=%0d, actual kind=%0d iface=%0d pin=%0d level=%0d last=%0d",
                   $time, want.event_kind, want.out_iface, want.out_pin, want.level, want.last,
                   out_data.event_kind, out_data.out_iface, out_data.out_pin, out_data.level,
                   out_data.last);
        end
      end
    end
  end

  initial begin
    int phase;
    int mark;
    logic [TICK_W-1:0] pause_val;
    clear_sequencer();
    pause_ticks = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_loop_pause('0);

    add_row(ctrl_req(OP_TICK), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_STOP), 1'b1, 1'b1, STOP_NOTICE);
    add_row(mk_req(OP_LOAD, 3'd7, 6'd63, '1, '1), 1'b1, 1'b0, '0);
    add_row(mk_req(OP_LOAD, 3'd6, 6'd0, '0, '0), 1'b1, 1'b0, '0);
    add_row(mk_req(OP_LOAD, 3'd0, 6'd0, '0, '0), 1'b1, 1'b1, low_evt(3'd0, 6'd0));
    add_row(mk_req(OP_LOAD, 3'd5, 6'd63, '1, '1), 1'b1, 1'b1, low_evt(3'd5, 6'd63));
    add_row(mk_req(OP_LOAD, 3'd1, 6'd21, 32'd1, 32'd2), 1'b1, 1'b1, low_evt(3'd1, 6'd21));
    add_row(mk_req(OP_LOAD, 3'd2, 6'd42, 32'd0, 32'd3), 1'b1, 1'b1, low_evt(3'd2, 6'd42));
    add_row(ctrl_req(OP_UNDEF), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_PAUSE), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_RESUME), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_START), 1'b1, 1'b0, '0);
    add_row(mk_req(OP_LOAD, 3'd3, 6'd7, '0, '0), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_START), 1'b1, 1'b0, '0);
    repeat (3) add_row(ctrl_req(OP_TICK), 1'b0, 1'b0, '0);
    add_row(ctrl_req(OP_PAUSE), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_STOP), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_TICK), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_RESUME), 1'b1, 1'b0, '0);
    repeat (2) add_row(ctrl_req(OP_TICK), 1'b0, 1'b0, '0);
    add_row(ctrl_req(OP_ABORT), 1'b1, 1'b0, '0);
    add_row(ctrl_req(OP_STOP), 1'b1, 1'b1, STOP_NOTICE);
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_evt,
                                   dir_rows[i].evt);

    phase = 0;
    while (active_reqs < REQ_TARGET) begin
      case (phase % 6)
        0: pause_val = 32'd1;
        1: pause_val = '1;
        2: pause_val = 32'd3;
        3: pause_val = '0;
        4: pause_val = $urandom_range(0, 6);
        default: pause_val = 32'd2;
      endcase
      write_loop_pause(pause_val);
      mark = active_reqs;
      while (active_reqs < mark + 70 && active_reqs < REQ_TARGET) run_pattern();
      phase++;
    end

    hold_requests(1);
    while (pin_events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pin_events_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/lpps_pkg.sv
hw/rtl/lpps_table.sv
hw/rtl/lpps_cmp.sv
hw/rtl/looped_pulse_pattern_sequencer.sv
tb/sv/tb_top.sv
